>>> sv/ssbi_pkg.sv
package ssbi_pkg;

    // Width of a query code and the largest number of sites.
    localparam int STATE_BITS = 32;
    localparam int MAX_SITES  = 16;

    // Width of one entry of the digit-sum count table and its saturation cap.
    localparam int WAYS_W = 63;
    localparam logic [WAYS_W-1:0] WAYS_CAP = {1'b1, {(WAYS_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [2:0] CFG_SITES      = 3'd0;
    localparam logic [2:0] CFG_TWICE_SPIN = 3'd1;
    localparam logic [2:0] CFG_USE_SECTOR = 3'd2;
    localparam logic [2:0] CFG_TARGET     = 3'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_TOO_WIDE = 2'd2;

    // Saturating add of two table counts.
    function automatic logic [WAYS_W-1:0] sat_add(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
        logic [WAYS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, WAYS_CAP}) ? WAYS_CAP : s[WAYS_W-1:0];
    endfunction

endpackage

>>> sv/ssbi_ways_mem.sv
module ssbi_ways_mem
    import ssbi_pkg::*;
#(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WAYS_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WAYS_W-1:0] o_rdata
);

    logic [WAYS_W-1:0] r_mem [1<<ADDR_W];
    logic [WAYS_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/spin_sector_basis_indexer.sv
// Full mode, too-wide and at-once sector misses: strobe the cycle after start is taken,
// one item a cycle while busy is low. Sector mode: per site, digit extraction (S_QDIG),
// a read (S_QRD) and add (S_QACC) per smaller digit value, then the strobe after S_QFIN;
// busy holds the next item off. Reset (synchronous, active low) and every register write
// rerun setup with busy high: powers of d, then the table if a sector target is reachable.
// Results appear for one cycle, marked by o_strobe; the receiver cannot stall.
module spin_sector_basis_indexer
    import ssbi_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_query_state,
    output logic        o_strobe,
    output logic        o_found,
    output logic [31:0] o_position,
    output logic [32:0] o_basis_size,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int IW   = $clog2(MAX_SITES + 1);
    localparam int SUMW = $clog2(MAX_SITES * 7 + 1);
    localparam int MW   = IW + 3;
    localparam int NW   = MW + 2;
    localparam int AW   = IW + SUMW;
    localparam int FW   = STATE_BITS + 1;
    localparam int QW   = (FW > 33) ? FW : 33;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_POW   = 12'b000000000010,
        S_BINIT = 12'b000000000100,
        S_BRD   = 12'b000000001000,
        S_BACC  = 12'b000000010000,
        S_BWR   = 12'b000000100000,
        S_TRD   = 12'b000001000000,
        S_TWAIT = 12'b000010000000,
        S_QDIG  = 12'b000100000000,
        S_QRD   = 12'b001000000000,
        S_QACC  = 12'b010000000000,
        S_QFIN  = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [4:0]        r_sites;
    logic [2:0]        r_twice_spin;
    logic              r_use_sector;
    logic signed [7:0] r_target;

    logic [FW-1:0]     r_full;
    logic [FW-1:0]     r_pow [1<<IW];
    logic              r_too_wide;
    logic [CW-1:0]     r_count;
    logic              r_ovf;

    logic [IW-1:0]     r_i;
    logic [SUMW-1:0]   r_s;
    logic [3:0]        r_v;
    logic [WAYS_W-1:0] r_acc;
    logic [FW-1:0]     r_rem;
    logic [1:0]        r_b;
    logic [2:0]        r_dig;
    logic [SUMW-1:0]   r_prefix;

    logic              r_strobe;
    logic              n_strobe;
    logic              r_found;
    logic [31:0]       r_pos;
    logic [32:0]       r_size;
    logic [1:0]        r_status;

    // Derived configuration values.
    logic [IW-1:0]     eff;
    logic [3:0]        dm;
    logic [3:0]        dd;
    logic [MW-1:0]     maxsum;
    logic signed [NW-1:0] num;
    logic              need_ok;
    logic [SUMW-1:0]   need;

    assign eff    = (r_sites > 5'(MAX_SITES)) ? IW'(MAX_SITES) : IW'(r_sites);
    assign dm     = {1'b0, r_twice_spin};
    assign dd     = dm + 4'd1;
    assign maxsum = MW'(eff) * MW'(dm);
    assign num    = NW'(r_target) + signed'(NW'(maxsum));
    assign need_ok = (num >= 0) && !num[0] && (num <= signed'(NW'({maxsum, 1'b0})));
    assign need   = SUMW'(num >>> 1);

    // Table memory ports.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WAYS_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WAYS_W-1:0] mem_rdata;

    ssbi_ways_mem #(.ADDR_W(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Build-loop terms.
    logic [IW-1:0]     im1;
    logic [MW-1:0]     lim_i;
    logic [MW-1:0]     lim_im1;
    logic [MW-1:0]     s_minus_v;
    logic              bterm_ok;

    assign im1       = r_i - 1'b1;
    assign lim_i     = MW'(r_i) * MW'(dm);
    assign lim_im1   = MW'(im1) * MW'(dm);
    assign s_minus_v = MW'(r_s) - MW'(r_v);
    assign bterm_ok  = (MW'(r_v) <= MW'(r_s)) && (s_minus_v <= lim_im1);

    // Query terms: current site index is r_i minus one.
    logic [FW+1:0]        shifted;
    logic                 take;
    logic signed [NW-1:0] rq;
    logic                 qterm_ok;

    assign shifted  = {2'b00, r_pow[im1]} << r_b;
    assign take     = {2'b00, r_rem} >= shifted;
    assign rq       = signed'(NW'(need)) - signed'(NW'(r_prefix)) - signed'(NW'(r_v));
    assign qterm_ok = (rq >= 0) && (rq <= signed'(NW'(lim_im1)));

    // Next power of the local dimension.
    logic [FW+3:0] prod;
    assign prod = (FW+4)'(r_full) * (FW+4)'(dd);

    logic q_in;
    assign q_in = QW'(i_query_state) < QW'(r_full);

    // A configuration write holds off a new item in the same cycle.
    logic accept;
    logic cfg_we;
    assign cfg_we = i_cfg_valid && o_cfg_ready;
    assign accept = start && !busy;

    // A result is strobed for items answered at once and at the end of a sector search.
    assign n_strobe = (accept && (r_too_wide || !r_use_sector || !(need_ok && q_in))) ||
                      (r_state == S_QFIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    // Memory addressing per state.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_i, r_s};
        mem_wdata = r_acc;
        mem_raddr = {im1, s_minus_v[SUMW-1:0]};
        unique case (r_state)
            S_BINIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = WAYS_W'(1);
            end
            S_BWR:   mem_we = 1'b1;
            S_TRD:   mem_raddr = {eff, need};
            S_QRD:   mem_raddr = {im1, rq[SUMW-1:0]};
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_POW;
            r_sites      <= 5'd1;
            r_twice_spin <= 3'd1;
            r_use_sector <= 1'b0;
            r_target     <= '0;
            r_i          <= '0;
            r_full       <= FW'(1);
            r_too_wide   <= 1'b0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
        end else if (cfg_we && (i_cfg_index == CFG_SITES || i_cfg_index == CFG_TWICE_SPIN ||
                                i_cfg_index == CFG_USE_SECTOR || i_cfg_index == CFG_TARGET)) begin
            // A register write restarts the rebuild.
            unique case (i_cfg_index)
                CFG_SITES:      r_sites      <= i_cfg_data[4:0];
                CFG_TWICE_SPIN: r_twice_spin <= i_cfg_data[2:0];
                CFG_USE_SECTOR: r_use_sector <= i_cfg_data[0];
                default:        r_target     <= signed'(i_cfg_data);
            endcase
            r_state    <= S_POW;
            r_i        <= '0;
            r_full     <= FW'(1);
            r_too_wide <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_too_wide) begin
                            r_found  <= 1'b0;
                            r_pos    <= '0;
                            r_size   <= '0;
                            r_status <= STAT_TOO_WIDE;
                        end else if (!r_use_sector) begin
                            r_size   <= 33'(r_full);
                            r_found  <= q_in;
                            r_pos    <= q_in ? i_query_state : '0;
                            r_status <= STAT_OK;
                        end else begin
                            r_found  <= 1'b0;
                            r_pos    <= '0;
                            r_size   <= 33'(r_count);
                            r_status <= r_ovf ? STAT_OVERFLOW : STAT_OK;
                            if (need_ok && q_in) begin
                                r_rem    <= FW'(i_query_state);
                                r_i      <= eff;
                                r_prefix <= '0;
                                r_acc    <= '0;
                                r_b      <= 2'd2;
                                r_dig    <= '0;
                                r_state  <= (eff == '0) ? S_QFIN : S_QDIG;
                            end
                        end
                    end
                end
                // Powers of d and d^N, stopping once the state width is exceeded.
                S_POW: begin
                    if (r_i < eff) begin
                        r_pow[r_i] <= r_full;
                        if (prod > (FW+4)'({1'b1, {STATE_BITS{1'b0}}})) begin
                            r_too_wide <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_full <= FW'(prod);
                            r_i    <= r_i + 1'b1;
                        end
                    end else if (r_use_sector && need_ok) begin
                        r_state <= S_BINIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_BINIT: begin
                    r_i     <= IW'(1);
                    r_s     <= '0;
                    r_v     <= '0;
                    r_acc   <= '0;
                    r_state <= (eff == '0) ? S_TRD : S_BRD;
                end
                // One term of ways[i][s] per read.
                S_BRD: begin
                    if (r_v > dm) begin
                        r_state <= S_BWR;
                    end else if (bterm_ok) begin
                        r_state <= S_BACC;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_BACC: begin
                    r_acc   <= sat_add(r_acc, mem_rdata);
                    r_v     <= r_v + 1'b1;
                    r_state <= S_BRD;
                end
                S_BWR: begin
                    r_acc <= '0;
                    r_v   <= '0;
                    if (MW'(r_s) == lim_i) begin
                        r_s <= '0;
                        if (r_i == eff) begin
                            r_state <= S_TRD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                S_TRD:   r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (mem_rdata > WAYS_W'(TABLE_DEPTH)) begin
                        r_count <= CW'(TABLE_DEPTH);
                        r_ovf   <= 1'b1;
                    end else begin
                        r_count <= CW'(mem_rdata);
                    end
                    r_state <= S_IDLE;
                end
                // Restoring extraction of one 3-bit digit.
                S_QDIG: begin
                    if (take) begin
                        r_rem <= FW'({2'b00, r_rem} - shifted);
                    end
                    r_dig[r_b] <= take;
                    if (r_b == 2'd0) begin
                        r_v     <= '0;
                        r_state <= S_QRD;
                    end else begin
                        r_b <= r_b - 1'b1;
                    end
                end
                // Count codes with a smaller digit at this site.
                S_QRD: begin
                    if (r_v < {1'b0, r_dig}) begin
                        if (qterm_ok) begin
                            r_state <= S_QACC;
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end else begin
                        r_prefix <= r_prefix + SUMW'(r_dig);
                        if (r_i == IW'(1)) begin
                            r_state <= S_QFIN;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_b     <= 2'd2;
                            r_state <= S_QDIG;
                        end
                    end
                end
                S_QACC: begin
                    r_acc   <= sat_add(r_acc, mem_rdata);
                    r_v     <= r_v + 1'b1;
                    r_state <= S_QRD;
                end
                S_QFIN: begin
                    if (r_prefix == need && r_acc < WAYS_W'(r_count)) begin
                        r_found <= 1'b1;
                        r_pos   <= 32'(r_acc);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE) || cfg_we;
    assign o_cfg_ready  = !(r_state == S_QDIG || r_state == S_QRD ||
                            r_state == S_QACC || r_state == S_QFIN);
    assign o_strobe     = r_strobe;
    assign o_found      = r_found;
    assign o_position   = r_pos;
    assign o_basis_size = r_size;
    assign o_status     = r_status;

    // A result is only strobed as the sequencer returns to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // Table overflow always clamps the count to the table depth.
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(TABLE_DEPTH)))
        else $error("overflow without clamped count");

    // A miss always reports position zero.
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_found) |-> (r_pos == '0))
        else $error("position nonzero on a miss");

    // No configuration is taken while a query is in flight.
    a_cfg_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRD || r_state == S_QDIG) |-> !o_cfg_ready)
        else $error("configuration open during query");

endmodule

>>> bench/spin_sector_basis_indexer_tb.sv
`timescale 1ns / 1ps
module spin_sector_basis_indexer_tb;
    import ssbi_pkg::*;

    localparam int DEPTH = 65536;
    localparam int MAXN = 16;
    localparam int WATCH_LIMIT = 200000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // Expected result of one item.
    typedef struct packed {
        logic        found;
        logic [31:0] position;
        logic [32:0] basis_size;
        logic [1:0]  status;
    } t_lookup;

    // Directed stimulus row: query plus optional typed-in answer.
    typedef struct {
        logic [31:0] query;
        bit          typed;
        t_lookup     answer;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_query_state = '0;
    logic        o_strobe;
    logic        o_found;
    logic [31:0] o_position;
    logic [32:0] o_basis_size;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    spin_sector_basis_indexer u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow configuration and derived basis description.
    logic [4:0]  sh_sites;
    logic [2:0]  sh_spin;
    logic        sh_sector;
    logic [7:0]  sh_target;
    int unsigned n_eff, dig_d, need_sum;
    longint unsigned full_dim, sect_count;
    bit          too_wide, need_ok, ovf;
    longint unsigned ways[MAXN+1][MAXN*7+1];

    t_lookup     pending[$];
    int          errors = 0;
    int          idle_cycles = 0;

    function automatic longint unsigned clip_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        longint unsigned cap;
        cap = 64'd1 << 62;
        s = a + b;
        return (s > cap || s < a) ? cap : s;
    endfunction

    // Rebuild the digit-sum count table for the current registers.
    task automatic rebuild_basis();
        int tgt, num;
        longint unsigned total;
        n_eff = (sh_sites > MAXN) ? MAXN : sh_sites;
        dig_d = sh_spin + 1;
        full_dim = 1;
        too_wide = 0;
        for (int i = 0; i < n_eff; i++) begin
            full_dim = full_dim * dig_d;
            if (full_dim > (64'd1 << 32)) begin
                too_wide = 1;
                break;
            end
        end
        tgt = $signed(sh_target);
        num = tgt + int'(n_eff * (dig_d - 1));
        need_ok = !(num < 0 || num[0] || num > 2 * int'(n_eff * (dig_d - 1)));
        need_sum = need_ok ? num / 2 : 0;
        for (int i = 0; i <= MAXN; i++)
            for (int s = 0; s <= MAXN*7; s++) ways[i][s] = 0;
        ways[0][0] = 1;
        for (int i = 1; i <= n_eff; i++)
            for (int s = 0; s <= i * (dig_d - 1); s++)
                for (int v = 0; v < dig_d && v <= s; v++)
                    ways[i][s] = clip_add(ways[i][s], ways[i-1][s-v]);
        sect_count = 0;
        ovf = 0;
        if (sh_sector && !too_wide && need_ok) begin
            total = ways[n_eff][need_sum];
            if (total > DEPTH) begin
                sect_count = DEPTH;
                ovf = 1;
            end else begin
                sect_count = total;
            end
        end
    endtask

    // Predict the lookup result of one query.
    function automatic t_lookup predict_lookup(logic [31:0] q);
        t_lookup r;
        int unsigned dg[MAXN];
        longint unsigned tmp, rank;
        int unsigned prefix;
        int rem;
        r = '0;
        if (too_wide) begin
            r.status = STAT_TOO_WIDE;
        end else if (!sh_sector) begin
            r.basis_size = 33'(full_dim);
            if (q < full_dim) begin
                r.found = 1'b1;
                r.position = q;
            end
        end else begin
            r.basis_size = 33'(sect_count);
            r.status = ovf ? STAT_OVERFLOW : STAT_OK;
            if (need_ok && q < full_dim) begin
                tmp = q;
                for (int i = 0; i < n_eff; i++) begin
                    dg[i] = 32'(tmp % dig_d);
                    tmp = tmp / dig_d;
                end
                rank = 0;
                prefix = 0;
                for (int i = n_eff - 1; i >= 0; i--) begin
                    for (int v = 0; v < dg[i]; v++) begin
                        rem = int'(need_sum) - int'(prefix) - v;
                        if (rem >= 0 && rem <= i * (dig_d - 1))
                            rank = clip_add(rank, ways[i][rem]);
                    end
                    prefix += dg[i];
                end
                if (prefix == need_sum && rank < sect_count) begin
                    r.found = 1'b1;
                    r.position = 32'(rank);
                end
            end
        end
        return r;
    endfunction

    // Check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        if (o_strobe) begin
            if (pending.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                t_lookup e;
                e = pending.pop_front();
                if (o_found !== e.found) begin
                    $error("found exp %0d got %0d", e.found, o_found);
                    errors++;
                end
                if (o_position !== e.position) begin
                    $error("position exp %0d got %0d", e.position, o_position);
                    errors++;
                end
                if (o_basis_size !== e.basis_size) begin
                    $error("basis_size exp %0d got %0d", e.basis_size, o_basis_size);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item, result or write.
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Issue one item; the expectation is queued at the accepting edge.
    // Start stays high afterwards so that the next item can follow at once.
    task automatic send_query(logic [31:0] q, bit typed, t_lookup ans);
        t_lookup e;
        e = typed ? ans : predict_lookup(q);
        start <= 1'b1;
        i_query_state <= q;
        do @(posedge i_clk); while (busy);
        pending = {pending, e};
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SITES:      sh_sites = val[4:0];
            CFG_TWICE_SPIN: sh_spin = val[2:0];
            CFG_USE_SECTOR: sh_sector = val[0];
            CFG_TARGET:     sh_target = val;
            default: ;
        endcase
        rebuild_basis();
        @(posedge i_clk);
    endtask

    task automatic set_all(int n, int sp, int sec, int tgt);
        write_reg(CFG_SITES, 8'(n));
        write_reg(CFG_TWICE_SPIN, 8'(sp));
        write_reg(CFG_USE_SECTOR, 8'(sec));
        write_reg(CFG_TARGET, 8'(tgt));
    endtask

    // Random query biased toward codes inside the basis.
    function automatic logic [31:0] pick_query();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7 && full_dim <= 64'hFFFFFFFF && !too_wide)
            return $urandom_range(0, 32'(full_dim - 1));
        if (p < 8) return $urandom;
        if (p < 9) return full_dim[31:0];
        return 32'hFFFFFFFF;
    endfunction

    t_row rows[4];
    t_lookup tmp_ans;

    initial begin
        sh_sites = 1;
        sh_spin = 1;
        sh_sector = 0;
        sh_target = 0;
        rebuild_basis();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part in the reset setting: full mode, two states.
        rows[0] = '{32'd0, 1'b1, '{1'b1, 32'd0, 33'd2, STAT_OK}};
        rows[1] = '{32'd1, 1'b1, '{1'b1, 32'd1, 33'd2, STAT_OK}};
        rows[2] = '{32'd2, 1'b1, '{1'b0, 32'd0, 33'd2, STAT_OK}};
        rows[3] = '{32'hFFFFFFFF, 1'b1, '{1'b0, 32'd0, 33'd2, STAT_OK}};
        foreach (rows[k]) begin
            send_query(rows[k].query, rows[k].typed, rows[k].answer);
            send_gap();
        end
        drain();

        // Sixteen sites of spin 3/2 exactly fill the state width.
        set_all(16, 3, 0, 0);
        tmp_ans = '{1'b1, 32'hFFFFFFFF, 33'h1_0000_0000, STAT_OK};
        send_query(32'hFFFFFFFF, 1'b1, tmp_ans);
        tmp_ans = '{1'b0, 32'd0, 33'd0, STAT_TOO_WIDE};
        drain();
        // Too wide: 16 sites of spin 7/2.
        set_all(16, 7, 1, 0);
        send_query(32'd0, 1'b1, tmp_ans);
        send_query(32'hFFFFFFFF, 1'b1, tmp_ans);
        drain();
        // Sites above the maximum act as the maximum; this sector overflows the table.
        set_all(31, 2, 1, 0);
        send_query(32'h00FF, 1'b0, tmp_ans);
        send_query(32'hFF00, 1'b0, tmp_ans);
        send_query(32'h5555, 1'b0, tmp_ans);
        drain();
        // Zero sites and zero spin.
        set_all(0, 0, 1, 0);
        send_query(32'd0, 1'b0, tmp_ans);
        send_query(32'd1, 1'b0, tmp_ans);
        drain();
        // Unreachable targets: odd parity and out of range.
        set_all(3, 2, 1, 1);
        send_query(32'd5, 1'b0, tmp_ans);
        write_reg(CFG_TARGET, 8'h90);
        send_query(32'd0, 1'b0, tmp_ans);
        write_reg(CFG_TARGET, 8'h70);
        send_query(32'd26, 1'b0, tmp_ans);
        drain();
        // Out-of-range register index is ignored.
        write_reg(CFG_UNUSED, 8'hFF);
        write_reg(CFG_TARGET, 8'h06);
        send_query(32'd26, 1'b0, tmp_ans);
        send_query(32'd25, 1'b0, tmp_ans);
        drain();

        // Random phases of new settings, mostly small chains.
        for (int ph = 0; ph < 40; ph++) begin
            int n, sp, mx, tg;
            sp = $urandom_range(0, 7);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
            mx = ((n > MAXN) ? MAXN : n) * sp;
            tg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) - 128
                                              : 2 * $urandom_range(0, mx) - mx;
            set_all(n, sp, $urandom_range(0, 5) != 0, tg);
            for (int k = 0; k < 35; k++) begin
                send_query(pick_query(), 1'b0, tmp_ans);
                send_gap();
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
